// ----- rtl/core/fie_pkg.sv -----
`default_nettype none

package fie_pkg;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Longest tag text is "<description>", 13 characters
    localparam int unsigned TAG_CHARS = 13;

    typedef enum logic [2:0] {
        TAG_ITEM        = 3'd0,
        TAG_TITLE       = 3'd1,
        TAG_LINK        = 3'd2,
        TAG_DESCRIPTION = 3'd3,
        TAG_PUBDATE     = 3'd4
    } tag_idx_t;

    typedef enum logic [1:0] {
        CMD_OPEN  = 2'd0,
        CMD_CLOSE = 2'd1,
        CMD_LIT   = 2'd2
    } cmd_kind_t;

    // One queued run of output bytes.
    // Literal runs: 1 = byte, 2 = '<' byte, 3 = '<' '/' byte
    typedef struct packed {
        cmd_kind_t   kind;
        tag_idx_t    tag;
        logic [1:0]  lit_count;
        logic [7:0]  lit_byte;
    } cmd_t;

    function automatic logic [3:0] tag_len(tag_idx_t tag);
        logic [3:0] len;
        case (tag)
            TAG_ITEM:        len = 4'd6;
            TAG_TITLE:       len = 4'd7;
            TAG_LINK:        len = 4'd6;
            TAG_DESCRIPTION: len = 4'd13;
            TAG_PUBDATE:     len = 4'd9;
            default:         len = 4'd6;
        endcase
        return len;
    endfunction

    // Tag text, right-justified in a field of TAG_CHARS bytes
    function automatic logic [TAG_CHARS*8-1:0] tag_text(tag_idx_t tag);
        logic [TAG_CHARS*8-1:0] text;
        case (tag)
            TAG_ITEM:        text = {56'h0, "<item>"};
            TAG_TITLE:       text = {48'h0, "<title>"};
            TAG_LINK:        text = {56'h0, "<link>"};
            TAG_DESCRIPTION: text = "<description>";
            TAG_PUBDATE:     text = {32'h0, "<pubDate>"};
            default:         text = {56'h0, "<item>"};
        endcase
        return text;
    endfunction

    function automatic logic [7:0] tag_char(tag_idx_t tag, logic [3:0] pos);
        logic [TAG_CHARS*8-1:0] text;
        logic [3:0]             len;
        logic [3:0]             sh;
        logic [7:0]             ch;
        text = tag_text(tag);
        len  = tag_len(tag);
        sh   = len - 4'd1 - pos;
        if (pos >= len) begin
            ch = 8'h00;
        end
        else begin
            ch = text[{sh, 3'b000} +: 8];
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fie_in_if.sv -----
`default_nettype none

interface fie_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/fie_out_if.sv -----
`default_nettype none

interface fie_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_in_run;

    modport source (output valid, output out_byte, output last_in_run, input ready);
    modport sink   (input valid, input out_byte, input last_in_run, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/fie_front.sv -----
`default_nettype none

module fie_front
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    fie_in_if.sink      feed,
    input  wire logic   full,
    output logic        push,
    output fie_pkg::cmd_t push_cmd
);

    typedef enum logic [8:0] {
        PH_SEEK_ITEM  = 9'b000000001,
        PH_SEEK_TITLE = 9'b000000010,
        PH_COPY_TITLE = 9'b000000100,
        PH_SEEK_LINK  = 9'b000001000,
        PH_COPY_LINK  = 9'b000010000,
        PH_SEEK_DESC  = 9'b000100000,
        PH_COPY_DESC  = 9'b001000000,
        PH_SEEK_DATE  = 9'b010000000,
        PH_COPY_DATE  = 9'b100000000
    } phase_t;

    typedef enum logic [2:0] {
        CS_TEXT     = 3'b001,
        CS_LT       = 3'b010,
        CS_LT_SLASH = 3'b100
    } copy_state_t;

    phase_t             phase_reg, phase_next, phase_adv;
    copy_state_t        copy_reg, copy_next;
    logic [3:0]         match_reg, match_next;
    logic               is_seek;
    fie_pkg::tag_idx_t  cur_tag;
    logic [3:0]         len;
    logic [7:0]         tag_ch;
    logic [7:0]         tag_first;
    logic [7:0]         b;
    logic               accept;
    logic               emit;

    assign feed.ready = !full;
    assign accept     = feed.valid && feed.ready;
    assign b          = feed.data_byte;

    always_comb
    begin
        case (phase_reg)
            PH_SEEK_ITEM:
            begin
                is_seek = 1'b1; cur_tag = fie_pkg::TAG_ITEM; phase_adv = PH_SEEK_TITLE;
            end
            PH_SEEK_TITLE:
            begin
                is_seek = 1'b1; cur_tag = fie_pkg::TAG_TITLE; phase_adv = PH_COPY_TITLE;
            end
            PH_COPY_TITLE:
            begin
                is_seek = 1'b0; cur_tag = fie_pkg::TAG_TITLE; phase_adv = PH_SEEK_LINK;
            end
            PH_SEEK_LINK:
            begin
                is_seek = 1'b1; cur_tag = fie_pkg::TAG_LINK; phase_adv = PH_COPY_LINK;
            end
            PH_COPY_LINK:
            begin
                is_seek = 1'b0; cur_tag = fie_pkg::TAG_LINK; phase_adv = PH_SEEK_DESC;
            end
            PH_SEEK_DESC:
            begin
                is_seek = 1'b1; cur_tag = fie_pkg::TAG_DESCRIPTION; phase_adv = PH_COPY_DESC;
            end
            PH_COPY_DESC:
            begin
                is_seek = 1'b0; cur_tag = fie_pkg::TAG_DESCRIPTION; phase_adv = PH_SEEK_DATE;
            end
            PH_SEEK_DATE:
            begin
                is_seek = 1'b1; cur_tag = fie_pkg::TAG_PUBDATE; phase_adv = PH_COPY_DATE;
            end
            PH_COPY_DATE:
            begin
                is_seek = 1'b0; cur_tag = fie_pkg::TAG_PUBDATE; phase_adv = PH_SEEK_ITEM;
            end
            default:
            begin
                is_seek = 1'b1; cur_tag = fie_pkg::TAG_ITEM; phase_adv = PH_SEEK_TITLE;
            end
        endcase
    end

    assign len       = fie_pkg::tag_len(cur_tag);
    assign tag_ch    = fie_pkg::tag_char(cur_tag, match_reg);
    assign tag_first = fie_pkg::tag_char(cur_tag, 4'd1);

    always_comb
    begin
        phase_next         = phase_reg;
        match_next         = match_reg;
        copy_next          = copy_reg;
        emit               = 1'b0;
        push_cmd.kind      = fie_pkg::CMD_LIT;
        push_cmd.tag       = cur_tag;
        push_cmd.lit_count = 2'd1;
        push_cmd.lit_byte  = b;

        if (is_seek)
        begin
            copy_next = CS_TEXT;
            if (match_reg == 4'd0 || match_reg >= len)
            begin
                match_next = (b == fie_pkg::CH_LT) ? 4'd1 : 4'd0;
            end
            else if (b == tag_ch)
            begin
                if (match_reg + 4'd1 == len)
                begin
                    emit          = 1'b1;
                    push_cmd.kind = fie_pkg::CMD_OPEN;
                    match_next    = 4'd0;
                    phase_next    = phase_adv;
                end
                else
                begin
                    match_next = match_reg + 4'd1;
                end
            end
            else
            begin
                // Broken match: a new '<' starts over as the first character
                match_next = (b == fie_pkg::CH_LT) ? 4'd1 : 4'd0;
            end
        end
        else
        begin
            match_next = 4'd0;
            case (copy_reg)
                CS_TEXT:
                begin
                    if (b == fie_pkg::CH_LT)
                    begin
                        copy_next = CS_LT;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                CS_LT:
                begin
                    if (b == fie_pkg::CH_SLASH)
                    begin
                        copy_next = CS_LT_SLASH;
                    end
                    else if (b == fie_pkg::CH_LT)
                    begin
                        // Release the older '<', keep the new one pending
                        emit = 1'b1;
                    end
                    else
                    begin
                        emit               = 1'b1;
                        push_cmd.lit_count = 2'd2;
                        copy_next          = CS_TEXT;
                    end
                end
                CS_LT_SLASH:
                begin
                    emit      = 1'b1;
                    copy_next = CS_TEXT;
                    if (b == tag_first)
                    begin
                        push_cmd.kind = fie_pkg::CMD_CLOSE;
                        phase_next    = phase_adv;
                    end
                    else
                    begin
                        push_cmd.lit_count = 2'd3;
                    end
                end
                default:
                begin
                    copy_next = CS_TEXT;
                end
            endcase
        end

        if (feed.stream_end)
        begin
            phase_next = PH_SEEK_ITEM;
            match_next = 4'd0;
            copy_next  = CS_TEXT;
            emit       = 1'b0;
        end
    end

    assign push = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEEK_ITEM;
            match_reg <= 4'd0;
            copy_reg  <= CS_TEXT;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            match_reg <= match_next;
            copy_reg  <= copy_next;
        end
    end

    a_copy_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        !is_seek |-> match_reg == 4'd0)
        else $error("match position left over in a copy phase");

    a_seek_plain_text: assert property (@(posedge clk) disable iff (!rst_n)
        is_seek |-> copy_reg == CS_TEXT)
        else $error("copy substate pending in a seek phase");

endmodule

`default_nettype wire

// ----- rtl/core/fie_queue.sv -----
`default_nettype none

module fie_queue
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire fie_pkg::cmd_t  push_cmd,
    output logic                full,
    input  wire logic           pop,
    output fie_pkg::cmd_t       head_cmd,
    output logic                empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    fie_pkg::cmd_t  entry_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

// ----- rtl/core/fie_back.sv -----
`default_nettype none

module fie_back
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire fie_pkg::cmd_t  head_cmd,
    input  wire logic           empty,
    output logic                pop,
    fie_out_if.source           extract
);

    logic [3:0] pos_reg, pos_next;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic [3:0] tlen;
    logic [3:0] run_len;
    logic [7:0] cur_byte;
    logic       cur_last;
    logic       step;

    assign tlen = fie_pkg::tag_len(head_cmd.tag);

    always_comb
    begin
        case (head_cmd.kind)
            fie_pkg::CMD_OPEN:
            begin
                run_len  = tlen;
                cur_byte = fie_pkg::tag_char(head_cmd.tag, pos_reg);
            end
            fie_pkg::CMD_CLOSE:
            begin
                run_len = tlen + 4'd1;
                if (pos_reg == 4'd0)
                begin
                    cur_byte = fie_pkg::CH_LT;
                end
                else if (pos_reg == 4'd1)
                begin
                    cur_byte = fie_pkg::CH_SLASH;
                end
                else
                begin
                    cur_byte = fie_pkg::tag_char(head_cmd.tag, pos_reg - 4'd1);
                end
            end
            default:
            begin
                run_len = {2'b00, head_cmd.lit_count};
                if (pos_reg == run_len - 4'd1)
                begin
                    cur_byte = head_cmd.lit_byte;
                end
                else if (pos_reg == 4'd0)
                begin
                    cur_byte = fie_pkg::CH_LT;
                end
                else
                begin
                    cur_byte = fie_pkg::CH_SLASH;
                end
            end
        endcase
    end

    assign cur_last = (pos_reg == run_len - 4'd1);
    // Advance whenever the queue holds a command and the output register is free or being drained
    assign step     = !empty && (!out_valid_reg || extract.ready);
    assign pop      = step && cur_last;
    assign pos_next = cur_last ? 4'd0 : pos_reg + 4'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                pos_reg       <= pos_next;
                out_valid_reg <= 1'b1;
            end
            else if (extract.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= cur_last;
        end
    end

    assign extract.valid       = out_valid_reg;
    assign extract.out_byte    = out_byte_reg;
    assign extract.last_in_run = out_last_reg;

    a_idle_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> pos_reg == 4'd0)
        else $error("run position not cleared while queue is empty");

    a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg && out_last_reg)
        else $error("finished run did not end with a last byte");

endmodule

`default_nettype wire

// ----- rtl/core/feed_item_field_extractor.sv -----
// The first output byte of a run passes through the command queue and then the output register.
// Throughput: one input byte per cycle while the queue is not full; the output side emits one byte per
// cycle while the sink is ready, so a tag run of up to 14 bytes holds the back end, absorbed by the queue.
// Input stalls only while the command queue (QUEUE_DEPTH entries) is full.
// Reset (rst_n low, asynchronous): seek <item>, no match, plain text, queue and output empty.
`default_nettype none

module feed_item_field_extractor
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    fie_in_if.sink      feed,
    fie_out_if.source   extract
);

    logic           push;
    fie_pkg::cmd_t  push_cmd;
    logic           full;
    logic           pop;
    fie_pkg::cmd_t  head_cmd;
    logic           empty;

    fie_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .feed     (feed),
        .full     (full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    fie_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (empty)
    );

    fie_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (head_cmd),
        .empty    (empty),
        .pop      (pop),
        .extract  (extract)
    );

endmodule

`default_nettype wire
